/* sv/websocket_frame_deframer_macros.svh */
// Assertion macros for the websocket frame deframer.
// Used by the front parser and the result queue; no other dependencies.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// property holds on every clock outside reset
`define WSD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a property in the next
`define WSD_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* sv/wsd_pkg.sv */
// Package for the websocket frame deframer: parse phases, opcodes, kinds,
// header constants and the queued result word. No dependencies.
`timescale 1ns / 1ps

package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HDR1,
      PH_HDR2,
      PH_EXT,
      PH_KEY,
      PH_BODY
   } phase_type;

   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;

   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_PING  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [6:0] LEN_EXT16   = 7'd126;
   localparam logic [6:0] LEN_EXT64   = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [2:0] KEY_BYTES   = 3'd4;

   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'h0200_0000;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] mask;
      logic       carries;
      logic [1:0] kind;
      logic       frame_end;
   } result_type;

endpackage

/* sv/wsd_front.sv */
// Front parser: header, extended length and mask key decode, body byte
// classification. Depends on wsd_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_macros.svh"

module wsd_front
   import wsd_pkg::*;
#(
   parameter int LENGTH_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  rx_byte,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output logic        push,
   output result_type  push_word
);

   localparam int LW = LENGTH_WIDTH;
   localparam int CW = (LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32;

   phase_type      phase_ff, phase_in;
   logic           halt_ff, halt_in;
   logic [31:0]    max_ff, max_in;
   logic [3:0]     opcode_ff, opcode_in;
   logic           mask_ff, mask_in;
   logic [3:0]     ext_left_ff, ext_left_in;
   logic [LW-1:0]  len_ff, len_in;
   logic           ovf_ff, ovf_in;
   logic [31:0]    key_ff, key_in;
   logic [2:0]     key_left_ff, key_left_in;
   logic [LW-1:0]  rem_ff, rem_in;
   logic [1:0]     idx_ff, idx_in;

   logic           live;
   logic           is_ext;
   logic [LW-1:0]  ext_len;
   logic [LW-1:0]  known_len;
   logic           known_ovf;
   logic           known_mask;
   logic           ext_last;
   logic           key_last;
   logic           body_last;
   logic           len_known;
   logic           too_big;
   logic           start_evt;
   logic [LW-1:0]  start_len;
   logic           start_zero;
   logic [7:0]     mask_byte;
   logic           halt_set;
   phase_type      len_next;

   always_comb begin
      live       = take && !halt_ff;
      is_ext     = (rx_byte[6:0] == LEN_EXT16) || (rx_byte[6:0] == LEN_EXT64);
      ext_len    = {len_ff[LW-9:0], rx_byte};
      ext_last   = (ext_left_ff <= 4'd1);
      key_last   = (key_left_ff <= 3'd1);
      body_last  = (rem_ff <= LW'(1));
      if (phase_ff == PH_EXT) begin
         known_len  = ext_len;
         known_ovf  = ovf_ff || (len_ff[LW-1:LW-8] != 8'd0);
         known_mask = mask_ff;
      end else begin
         known_len  = LW'(rx_byte[6:0]);
         known_ovf  = 1'b0;
         known_mask = rx_byte[7];
      end
      too_big    = known_ovf || (CW'(known_len) > CW'(max_ff));
      len_known  = live && (((phase_ff == PH_HDR2) && !is_ext) ||
                            ((phase_ff == PH_EXT) && ext_last));
      start_len  = (phase_ff == PH_KEY) ? len_ff : known_len;
      start_zero = (start_len == '0);
      start_evt  = (len_known && !too_big && !known_mask) ||
                   (live && (phase_ff == PH_KEY) && key_last);
      case (idx_ff)
         2'd0:    mask_byte = key_ff[31:24];
         2'd1:    mask_byte = key_ff[23:16];
         2'd2:    mask_byte = key_ff[15:8];
         default: mask_byte = key_ff[7:0];
      endcase
      if (!mask_ff) begin
         mask_byte = 8'd0;
      end
      if (too_big) begin
         len_next = PH_HDR1;
      end else if (known_mask) begin
         len_next = PH_KEY;
      end else if (start_zero) begin
         len_next = PH_HDR1;
      end else begin
         len_next = PH_BODY;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (live) begin
         unique case (phase_ff)
            PH_HDR1: begin
               phase_in = PH_HDR2;
            end
            PH_HDR2: begin
               phase_in = is_ext ? PH_EXT : len_next;
            end
            PH_EXT: begin
               if (ext_last) begin
                  phase_in = len_next;
               end
            end
            PH_KEY: begin
               if (key_last) begin
                  phase_in = start_zero ? PH_HDR1 : PH_BODY;
               end
            end
            PH_BODY: begin
               if (body_last) begin
                  phase_in = PH_HDR1;
               end
            end
            default: begin
               phase_in = PH_HDR1;
            end
         endcase
      end
   end

   // result words
   always_comb begin
      push      = 1'b0;
      push_word = '0;
      halt_set  = 1'b0;
      if (len_known && too_big) begin
         push                = 1'b1;
         push_word.kind      = KIND_ERROR;
         push_word.frame_end = 1'b1;
         halt_set            = 1'b1;
      end else if (start_evt && start_zero) begin
         push_word.frame_end = 1'b1;
         case (opcode_ff)
            OP_TEXT: begin
               push           = 1'b1;
               push_word.kind = KIND_TEXT;
            end
            OP_PING: begin
               push           = 1'b1;
               push_word.kind = KIND_PING;
            end
            OP_CLOSE: begin
               push           = 1'b1;
               push_word.kind = KIND_CLOSE;
               halt_set       = 1'b1;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end else if (live && (phase_ff == PH_BODY)) begin
         case (opcode_ff) inside
            OP_TEXT, OP_PING: begin
               push                = 1'b1;
               push_word.data      = rx_byte;
               push_word.mask      = mask_byte;
               push_word.carries   = 1'b1;
               push_word.kind      = (opcode_ff == OP_TEXT) ? KIND_TEXT : KIND_PING;
               push_word.frame_end = body_last;
            end
            OP_CLOSE: begin
               if (body_last) begin
                  push                = 1'b1;
                  push_word.kind      = KIND_CLOSE;
                  push_word.frame_end = 1'b1;
                  halt_set            = 1'b1;
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   // datapath registers
   always_comb begin
      halt_in     = halt_ff || halt_set;
      max_in      = csr_wr_en ? csr_wr_data : max_ff;
      opcode_in   = opcode_ff;
      mask_in     = mask_ff;
      ext_left_in = ext_left_ff;
      len_in      = len_ff;
      ovf_in      = ovf_ff;
      key_in      = key_ff;
      key_left_in = key_left_ff;
      rem_in      = rem_ff;
      idx_in      = idx_ff;
      if (live) begin
         case (phase_ff)
            PH_HDR1: begin
               opcode_in = rx_byte[3:0];
            end
            PH_HDR2: begin
               mask_in     = rx_byte[7];
               ovf_in      = 1'b0;
               len_in      = is_ext ? '0 : known_len;
               ext_left_in = (rx_byte[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            end
            PH_EXT: begin
               len_in      = ext_len;
               ovf_in      = known_ovf;
               ext_left_in = ext_last ? 4'd0 : ext_left_ff - 4'd1;
            end
            PH_KEY: begin
               key_in      = {key_ff[23:0], rx_byte};
               key_left_in = key_last ? 3'd0 : key_left_ff - 3'd1;
            end
            PH_BODY: begin
               rem_in = rem_ff - LW'(1);
               idx_in = idx_ff + 2'd1;
            end
            default: begin
               opcode_in = opcode_ff;
            end
         endcase
         if (len_known && known_mask) begin
            key_left_in = KEY_BYTES;
         end
      end
      if (start_evt) begin
         rem_in = start_len;
         idx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR1;
         halt_ff  <= 1'b0;
         max_ff   <= MAX_PAYLOAD_RESET;
      end else begin
         phase_ff <= phase_in;
         halt_ff  <= halt_in;
         max_ff   <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff   <= opcode_in;
      mask_ff     <= mask_in;
      ext_left_ff <= ext_left_in;
      len_ff      <= len_in;
      ovf_ff      <= ovf_in;
      key_ff      <= key_in;
      key_left_ff <= key_left_in;
      rem_ff      <= rem_in;
      idx_ff      <= idx_in;
   end

   `WSD_ASSERT_NEXT(a_halt_sticks, clock, reset, halt_ff, halt_ff, "halt released before reset")
   `WSD_ASSERT(a_no_word_halted, clock, reset, !(push && halt_ff), "word pushed while halted")
   `WSD_ASSERT(a_push_needs_take, clock, reset, !push || take, "word pushed without input word")

endmodule

/* sv/wsd_queue.sv */
// Short result queue between the front parser and the output stage.
// Flip-flop storage, combinational head read. Depends on wsd_pkg and macros.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_macros.svh"

module wsd_queue
   import wsd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_word,
   input  logic       pop,
   output logic       full,
   output logic       head_valid,
   output result_type head_word
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   result_type        store_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;

   always_comb begin
      full       = (count_ff == CNTW'(DEPTH));
      head_valid = (count_ff != '0);
      head_word  = store_ff[rd_ptr_ff];
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_word;
      end
   end

   `WSD_ASSERT(a_q_bound, clock, reset, count_ff <= CNTW'(DEPTH), "queue count over depth")
   `WSD_ASSERT(a_q_pop_empty, clock, reset, !(pop && !head_valid), "pop from empty queue")
   `WSD_ASSERT_NEXT(a_q_grow, clock, reset, push && !pop,
                    count_ff == $past(count_ff) + CNTW'(1), "queue count did not grow")

endmodule

/* sv/wsd_back.sv */
// Output stage: unmasks the queued word and holds it for the result channel.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_back
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  result_type head_word,
   output logic       pop,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_carries_byte,
   output logic [1:0] rsp_frame_kind,
   output logic       rsp_frame_end
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       carries_ff, carries_in;
   logic [1:0] kind_ff, kind_in;
   logic       end_ff, end_in;

   always_comb begin
      pop        = head_valid && (!valid_ff || !rsp_stall);
      valid_in   = pop || (valid_ff && rsp_stall);
      data_in    = data_ff;
      carries_in = carries_ff;
      kind_in    = kind_ff;
      end_in     = end_ff;
      if (pop) begin
         data_in    = head_word.data ^ head_word.mask;
         carries_in = head_word.carries;
         kind_in    = head_word.kind;
         end_in     = head_word.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff    <= data_in;
      carries_ff <= carries_in;
      kind_ff    <= kind_in;
      end_ff     <= end_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_carries_byte = carries_ff;
   assign rsp_frame_kind   = kind_ff;
   assign rsp_frame_end    = end_ff;

endmodule

/* sv/websocket_frame_deframer.sv */
// WebSocket frame deframer top level: front parser, result queue, output stage.
// Depends on wsd_pkg, wsd_front, wsd_queue and wsd_back.
//
// Usage:
//  - req channel: one received word (byte) per accepted req_valid/!req_stall,
//    starting at a frame boundary. Up to one word per cycle.
//  - rsp channel: unmasked payload bytes of text and ping frames, empty-frame
//    markers, close and oversize reports; frame_end flags the last word of a frame.
//  - csr: csr_wr_en writes max_payload_length; write it only while idle.
//  - Result path: a result word is registered first in the queue and then in the
//    output stage register before it shows on rsp_valid.
//  - Throughput: one input word per cycle while req_stall is low, set by the front parser,
//    which takes each accepted word as it comes, and a one-word-per-cycle output stage.
//  - Receiver stall: results pile up in a QUEUE_DEPTH-word queue; when it is
//    full req_stall rises until the output stage drains a word.
//  - After a close or an oversize report all input words are swallowed until reset.
//  - Reset (synchronous) empties the queue, returns to the first header byte,
//    clears the halt and loads the 32 MiB default limit.
`timescale 1ns / 1ps

module websocket_frame_deframer
   import wsd_pkg::*;
#(
   parameter int LENGTH_WIDTH = 64,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_carries_byte,
   output logic [1:0]  rsp_frame_kind,
   output logic        rsp_frame_end,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic       take;
   logic       push;
   result_type push_word;
   logic       q_full;
   logic       q_valid;
   result_type q_word;
   logic       q_pop;

   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   wsd_front #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .rx_byte    (req_rx_byte),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .push       (push),
      .push_word  (push_word)
   );

   wsd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (q_pop),
      .full      (q_full),
      .head_valid(q_valid),
      .head_word (q_word)
   );

   wsd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_valid),
      .head_word       (q_word),
      .pop             (q_pop),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_carries_byte(rsp_carries_byte),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule
